// File: rtl/spq_pkg.sv
// package: widths, entry and command types, status codes for the priority queue
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_WIDTH = 16;
  localparam int PRIO_W    = 4;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int IN_BITS   = 1 + PRIO_W + TAG_WIDTH;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 + 1 + PRIO_W + TAG_WIDTH + CNT_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } spq_action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_WIDTH-1:0] tag;
  } spq_entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [PRIO_W-1:0] prio;
    logic [TAG_WIDTH-1:0] tag;
  } spq_cmd_t;

endpackage

// File: rtl/spq_cell.sv
// one slot of the sorted row: compare against the new entry, hold or shift
`timescale 1ns / 1ps
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_entry_t left_i,
  input  logic                left_keep_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic                keep_o
);
  import spq_pkg::*;

  logic                 valid_q, valid_d;
  logic [PRIO_W-1:0]    prio_q, prio_d;
  logic [TAG_WIDTH-1:0] tag_q, tag_d;

  // equal priority stays ahead of the new entry, which keeps the order stable
  assign keep_o = valid_q && (prio_q >= cmd_i.prio);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    if (cmd_i.rem) begin
      valid_d = right_i.valid;
      prio_d  = right_i.prio;
      tag_d   = right_i.tag;
    end else if (cmd_i.ins && !keep_o) begin
      if (left_keep_i) begin
        valid_d = 1'b1;
        prio_d  = cmd_i.prio;
        tag_d   = cmd_i.tag;
      end else begin
        valid_d = left_i.valid;
        prio_d  = left_i.prio;
        tag_d   = left_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign entry_o = '{valid: valid_q, prio: prio_q, tag: tag_q};

endmodule

// File: rtl/stable_priority_queue.sv
// top level: stream ports, entry count, result register and the row of cells
// the result of an item is registered and offered in the cycle after its transfer
// throughput: one item per cycle while results are taken; each cell decides hold, shift or load locally
// the input waits only while an unread result sits in the output register
// reset empties the queue (cell valid bits and count cleared), no result pending
`timescale 1ns / 1ps
module stable_priority_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [spq_pkg::IN_W-1:0] s_axis_tdata,  // action, priority_req, tag
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [spq_pkg::OUT_W-1:0] m_axis_tdata  // status, head_valid, head_priority,
                                                  // head_tag, entry_count
);
  import spq_pkg::*;

  spq_action_e          action;
  logic [PRIO_W-1:0]    priority_req;
  logic [TAG_WIDTH-1:0] tag;
  logic                 in_xfer;
  logic                 full, empty;

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  spq_status_e          status_q, status_d;

  spq_cmd_t             cmd;
  spq_entry_t           entries [DEPTH];
  logic [DEPTH-1:0]     keeps;

  assign action       = spq_action_e'(s_axis_tdata[0]);
  assign priority_req = s_axis_tdata[PRIO_W:1];
  assign tag          = s_axis_tdata[PRIO_W+TAG_WIDTH:PRIO_W+1];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(DEPTH));
  assign empty         = (count_q == '0);

  always_comb begin
    cmd.ins     = in_xfer && (action == ACT_INSERT) && !full;
    cmd.rem     = in_xfer && (action == ACT_REMOVE) && !empty;
    cmd.prio    = priority_req;
    cmd.tag     = tag;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      unique case (action)
        ACT_INSERT: begin
          status_d = full ? ST_FULL : ST_DONE;
          if (!full) count_d = count_q + CNT_W'(1);
        end
        ACT_REMOVE: begin
          status_d = empty ? ST_EMPTY : ST_DONE;
          if (!empty) count_d = count_q - CNT_W'(1);
        end
        default: status_d = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left, right;
    logic       left_keep;
    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_inner
      assign left      = entries[i-1];
      assign left_keep = keeps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = entries[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .entry_o     (entries[i]),
      .keep_o      (keeps[i])
    );
  end

  // the head cell already holds the state after the transfer that made this result
  logic                 head_valid;
  logic [PRIO_W-1:0]    head_priority;
  logic [TAG_WIDTH-1:0] head_tag;

  assign head_valid    = entries[0].valid;
  assign head_priority = head_valid ? entries[0].prio : '0;
  assign head_tag      = head_valid ? entries[0].tag : '0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({count_q, head_tag, head_priority, head_valid, status_q});

endmodule

// File: dv/tb_top.sv
// testbench: random and directed insert/remove traffic with a self-checking queue predictor
`timescale 1ns / 1ps
module tb_top;
  import spq_pkg::*;

  localparam int RANDOM_OPS  = 1930;
  localparam int HOLD_AT_OP  = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;

  // tdata layout, lowest field first: action, priority_req, tag
  typedef struct packed {
    logic [TAG_WIDTH-1:0] tag;
    logic [PRIO_W-1:0]    prio;
    spq_action_e          action;
  } queue_op_t;

  // tdata layout, lowest field first: status, head_valid, head_priority, head_tag, entry_count
  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic [TAG_WIDTH-1:0] tag;
    logic [PRIO_W-1:0]    prio;
    logic                 valid;
    spq_status_e          status;
  } head_report_t;

  class spq_scoreboard;
    logic [PRIO_W-1:0]    prio_q [DEPTH];
    logic [TAG_WIDTH-1:0] tag_q [DEPTH];
    int unsigned          held;
    head_report_t         pending_reports[$];
    int unsigned          fail_count;
    int unsigned          checked;

    function new();
      held = 0;
      fail_count = 0;
      checked = 0;
    endfunction

    // advance the queue model by one operation and queue the report it yields
    function void note_input(queue_op_t op);
      head_report_t rep;
      int unsigned  pos;
      rep.status = ST_DONE;
      if (op.action == ACT_INSERT) begin
        if (held >= DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          pos = 0;
          // stable: go behind every entry of equal or higher priority
          while (pos < held && op.prio <= prio_q[pos]) pos++;
          for (int i = held; i > pos; i--) begin
            prio_q[i] = prio_q[i-1];
            tag_q[i]  = tag_q[i-1];
          end
          prio_q[pos] = op.prio;
          tag_q[pos]  = op.tag;
          held++;
        end
      end else begin
        if (held == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < held; i++) begin
            prio_q[i] = prio_q[i+1];
            tag_q[i]  = tag_q[i+1];
          end
          held--;
        end
      end
      rep.valid = (held > 0);
      rep.prio  = (held > 0) ? prio_q[0] : '0;
      rep.tag   = (held > 0) ? tag_q[0] : '0;
      rep.count = CNT_W'(held);
      pending_reports.push_back(rep);
    endfunction

    function void check_result(head_report_t got);
      head_report_t want;
      logic         bad;
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status=%0d valid=%0d prio=%0d tag=%h count=%0d",
                   got.status, got.valid, got.prio, got.tag, got.count);
        return;
      end
      want = pending_reports.pop_front();
      bad = (got.status !== want.status) || (got.valid !== want.valid) ||
            (got.prio !== want.prio) || (got.tag !== want.tag) ||
            (got.count !== want.count);
      if (bad) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d: exp st=%0d v=%0d p=%0d t=%h n=%0d got st=%0d v=%0d p=%0d t=%h n=%0d",
                   checked, want.status, want.valid, want.prio, want.tag, want.count,
                   got.status, got.valid, got.prio, got.tag, got.count);
      end
      checked++;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_axis_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  spq_scoreboard sb;
  int            burst_left;
  bit            hold_req;

  stable_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfers on both sides are observed with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready)
        sb.check_result(head_report_t'(m_axis_tdata[OUT_BITS-1:0]));
      if (s_tvalid && s_axis_tready)
        sb.note_input(queue_op_t'(s_tdata[IN_BITS-1:0]));
    end
  end

  // receiver: a randomly chosen stall mode, plus one long hold-off on request
  initial begin
    int unsigned rx_cyc;
    int unsigned rx_mode;
    rx_cyc  = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cyc[2:0] != 3'd5) && (rx_cyc[2:0] != 3'd6);
        endcase
        rx_cyc++;
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic queue_op_t make_op(spq_action_e act, int unsigned prio, int unsigned tag);
    queue_op_t op;
    op.action = act;
    op.prio   = PRIO_W'(prio);
    op.tag    = TAG_WIDTH'(tag);
    return op;
  endfunction

  // offer one item, wait for its transfer, then maybe end the burst with a gap
  task automatic send_op(input queue_op_t op);
    int unsigned gap;
    s_tdata  <= IN_W'(op);
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
  endtask

  initial begin
    int unsigned phase_left;
    int unsigned insert_bias;
    int unsigned prio;
    spq_action_e act;
    sb          = new();
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    hold_req    = 1'b0;
    burst_left  = 4;
    phase_left  = 0;
    insert_bias = 50;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // remove on empty, with the ignored fields at their top values
    send_op(make_op(ACT_REMOVE, 15, 16'hffff));
    send_op(make_op(ACT_INSERT, 0, 16'h0000));
    send_op(make_op(ACT_INSERT, 15, 16'hffff));
    // equal priority must queue behind the earlier entry
    send_op(make_op(ACT_INSERT, 15, 16'h0001));
    send_op(make_op(ACT_INSERT, 7, 16'h1234));
    send_op(make_op(ACT_INSERT, 0, 16'h8000));
    for (int i = 0; i < 11; i++)
      send_op(make_op(ACT_INSERT, (i * 5) % 16, 16'ha500 + i));
    // queue is full here, this one is dropped
    send_op(make_op(ACT_INSERT, 15, 16'h5a5a));
    repeat (3) send_op(make_op(ACT_REMOVE, 0, 16'h0000));

    // random part: insert-heavy and remove-heavy phases sweep between full and empty
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: insert_bias = 85;
          1: insert_bias = 15;
          default: insert_bias = 50;
        endcase
        phase_left = $urandom_range(10, 50);
      end
      phase_left--;
      if (n == HOLD_AT_OP) hold_req = 1'b1;
      act  = ($urandom_range(0, 99) < insert_bias) ? ACT_INSERT : ACT_REMOVE;
      // narrow priority range half the time so ties are common
      prio = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      send_op(make_op(act, prio, $urandom_range(0, 65535)));
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
dv/tb_top.sv
